FILE: rtl/rbbf_pkg.sv
// Package for the ring buffer burst FIFO core: field widths, function and
// status codes, and the command type passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package rbbf_pkg;

	localparam int FUNC_W    = 2;
	localparam int CNT_W     = 7;
	localparam int DATA_W    = 32;
	localparam int FILL_W    = 10;
	localparam int LEN_CFG_W = 11;
	localparam int STAT_W    = 2;

	localparam int DEPTH_DEF     = 1024;
	localparam int ELEM_BITS_DEF = 32;
	localparam int MAX_BURST_DEF = 64;
	localparam int LEN_RESET     = 1024;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd3;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_READ,
		CMD_QUERY,
		CMD_BAD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              count_ok;
		logic [CNT_W-1:0]  count;
		logic [DATA_W-1:0] data;
	} cmd_t;

endpackage

FILE: rtl/ring_buffer_burst_fifo_core.sv
// Ring buffer burst FIFO core. The last element of a write burst, a query or a
// refused request gives its result via the command queue and result registers; a
// read burst of N elements gives N results on consecutive cycles, one per cycle from
// the single memory read port. A two-entry command queue accepts a request per cycle
// until a read burst fills it. Results carry a one-cycle done strobe and cannot be
// held off. Asynchronous reset empties the FIFO and sets the length to min(1024, DEPTH) slots.
`timescale 1ns / 1ps

module ring_buffer_burst_fifo_core import rbbf_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int ELEM_BITS = ELEM_BITS_DEF,
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 length_in_use_wr,
	input  logic [LEN_CFG_W-1:0] length_in_use,
	input  logic [FUNC_W-1:0]    func,
	input  logic [CNT_W-1:0]     burst_count,
	input  logic [DATA_W-1:0]    write_data,
	output logic                 done,
	output logic [STAT_W-1:0]    status,
	output logic [DATA_W-1:0]    read_data,
	output logic                 last,
	output logic [FILL_W-1:0]    filled,
	output logic [FILL_W-1:0]    unfilled,
	output logic                 fifo_empty,
	output logic                 is_full
);

	logic push, pop, q_empty, q_full;
	cmd_t cmd_in, cmd_out;

	assign busy = q_full;

	rbbf_front #(
		.MAX_BURST(MAX_BURST)
	) u_front (
		.start       (start),
		.busy        (busy),
		.func        (func),
		.burst_count (burst_count),
		.write_data  (write_data),
		.push        (push),
		.cmd         (cmd_in)
	);

	rbbf_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_in),
		.pop     (pop),
		.cmd_out (cmd_out),
		.empty   (q_empty),
		.full    (q_full)
	);

	rbbf_back #(
		.DEPTH     (DEPTH),
		.ELEM_BITS (ELEM_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (length_in_use_wr),
		.cfg_len    (length_in_use),
		.cmd_valid  (~q_empty),
		.cmd        (cmd_out),
		.cmd_pop    (pop),
		.done       (done),
		.status     (status),
		.read_data  (read_data),
		.last       (last),
		.filled     (filled),
		.unfilled   (unfilled),
		.fifo_empty (fifo_empty),
		.is_full    (is_full)
	);

endmodule

FILE: rtl/rbbf_front.sv
// Front end of the ring buffer burst FIFO core: takes a request and sorts it
// into a command with its count already checked. Depends on rbbf_pkg.
`timescale 1ns / 1ps

module rbbf_front import rbbf_pkg::*; #(
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic              start,
	input  logic              busy,
	input  logic [FUNC_W-1:0] func,
	input  logic [CNT_W-1:0]  burst_count,
	input  logic [DATA_W-1:0] write_data,
	output logic              push,
	output cmd_t              cmd
);

	always_comb begin
		push         = start & ~busy;
		cmd.count    = burst_count;
		cmd.data     = write_data;
		cmd.count_ok = (burst_count != '0) && (burst_count <= CNT_W'(MAX_BURST));
		unique case (func)
			FUNC_WRITE: cmd.kind = CMD_WRITE;
			FUNC_READ:  cmd.kind = CMD_READ;
			FUNC_QUERY: cmd.kind = CMD_QUERY;
			default:    cmd.kind = CMD_BAD;
		endcase
	end

endmodule

FILE: rtl/rbbf_cmd_queue.sv
// Two-entry command queue between the front end and the back end of the
// ring buffer burst FIFO core. Depends on rbbf_pkg.
`timescale 1ns / 1ps

module rbbf_cmd_queue import rbbf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t cmd_in,
	input  logic pop,
	output cmd_t cmd_out,
	output logic empty,
	output logic full
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign empty   = (count_q == 2'd0);
	assign full    = (count_q == 2'd2);
	assign cmd_out = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/rbbf_back.sv
// Back end of the ring buffer burst FIFO core: the slot memory, ring indices,
// fill count, write burst tracking, read burst sequencing and the result
// register. Depends on rbbf_pkg.
`timescale 1ns / 1ps

module rbbf_back import rbbf_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr,
	input  logic [LEN_CFG_W-1:0] cfg_len,
	input  logic                 cmd_valid,
	input  cmd_t                 cmd,
	output logic                 cmd_pop,
	output logic                 done,
	output logic [STAT_W-1:0]    status,
	output logic [DATA_W-1:0]    read_data,
	output logic                 last,
	output logic [FILL_W-1:0]    filled,
	output logic [FILL_W-1:0]    unfilled,
	output logic                 fifo_empty,
	output logic                 is_full
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W = $clog2(DEPTH + 1);
	localparam int LEN_RST = (DEPTH < LEN_RESET) ? DEPTH : LEN_RESET;

	logic [ELEM_BITS-1:0] mem [DEPTH];
	logic [ELEM_BITS-1:0] mem_q;

	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] rd_idx_q, wr_idx_q;
	logic [LEN_W-1:0] fill_q;
	logic [CNT_W-1:0] rem_q;
	logic             ok_q;
	logic             rd_active_q;
	logic [CNT_W-1:0] rd_left_q;

	logic              done_s1;
	logic [STAT_W-1:0] status_s1;
	logic              last_s1;
	logic              rdsel_s1;
	logic [LEN_W-1:0]  fill_s1;
	logic [LEN_W-1:0]  unfill_s1;

	logic [IDX_W-1:0]  rd_idx_d, wr_idx_d;
	logic [LEN_W-1:0]  fill_d;
	logic [CNT_W-1:0]  rem_d, rem_eff, rd_left_d;
	logic              ok_d, ok_eff, rd_active_d;
	logic              mem_we, mem_re;
	logic              emit, emit_last, emit_rd;
	logic [STAT_W-1:0] emit_status;
	logic [LEN_W-1:0]  unfill_now;
	logic [LEN_W-1:0]  len_clamped;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
			input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] n;
		n = LEN_W'(idx) + LEN_W'(1);
		return (n >= len) ? '0 : IDX_W'(n);
	endfunction

	always_comb begin
		if (32'(cfg_len) < 32'd2) begin
			len_clamped = LEN_W'(2);
		end else if (32'(cfg_len) > 32'(DEPTH)) begin
			len_clamped = LEN_W'(DEPTH);
		end else begin
			len_clamped = LEN_W'(cfg_len);
		end
	end

	assign unfill_now = len_q - LEN_W'(1) - fill_q;
	assign cmd_pop    = cmd_valid & ~rd_active_q;

	always_comb begin
		rd_idx_d    = rd_idx_q;
		wr_idx_d    = wr_idx_q;
		fill_d      = fill_q;
		rem_d       = rem_q;
		ok_d        = ok_q;
		rd_active_d = rd_active_q;
		rd_left_d   = rd_left_q;
		rem_eff     = rem_q;
		ok_eff      = ok_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		emit        = 1'b0;
		emit_last   = 1'b1;
		emit_rd     = 1'b0;
		emit_status = STAT_OK;
		if (rd_active_q) begin
			mem_re    = 1'b1;
			rd_idx_d  = next_idx(rd_idx_q, len_q);
			fill_d    = fill_q - LEN_W'(1);
			emit      = 1'b1;
			emit_rd   = 1'b1;
			emit_last = (rd_left_q == CNT_W'(1));
			rd_left_d = rd_left_q - CNT_W'(1);
			if (rd_left_q == CNT_W'(1)) begin
				rd_active_d = 1'b0;
			end
		end else if (cmd_pop) begin
			unique case (cmd.kind)
				CMD_WRITE: begin
					if ((rem_q == '0) && !cmd.count_ok) begin
						emit        = 1'b1;
						emit_status = STAT_INVALID;
					end else begin
						if (rem_q == '0) begin
							rem_eff = cmd.count;
							ok_eff  = (32'(cmd.count) <= 32'(unfill_now));
						end
						if (ok_eff) begin
							mem_we   = 1'b1;
							wr_idx_d = next_idx(wr_idx_q, len_q);
							fill_d   = fill_q + LEN_W'(1);
						end
						rem_d = rem_eff - CNT_W'(1);
						ok_d  = ok_eff;
						if (rem_eff == CNT_W'(1)) begin
							emit        = 1'b1;
							emit_status = ok_eff ? STAT_OK : STAT_FULL;
							ok_d        = 1'b0;
						end
					end
				end
				CMD_READ: begin
					if (!cmd.count_ok) begin
						emit        = 1'b1;
						emit_status = STAT_INVALID;
					end else if (32'(cmd.count) > 32'(fill_q)) begin
						emit        = 1'b1;
						emit_status = STAT_EMPTY;
					end else begin
						rd_active_d = 1'b1;
						rd_left_d   = cmd.count;
					end
				end
				CMD_QUERY: begin
					emit = 1'b1;
				end
				CMD_BAD: begin
					emit        = 1'b1;
					emit_status = STAT_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx_q] <= ELEM_BITS'(cmd.data);
		end
		if (mem_re) begin
			mem_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= emit_status;
		last_s1   <= emit_last;
		rdsel_s1  <= emit_rd;
		fill_s1   <= fill_d;
		unfill_s1 <= len_q - LEN_W'(1) - fill_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_W'(LEN_RST);
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			fill_q      <= '0;
			rem_q       <= '0;
			ok_q        <= 1'b0;
			rd_active_q <= 1'b0;
			rd_left_q   <= '0;
			done_s1     <= 1'b0;
		end else begin
			done_s1 <= emit;
			if (cfg_wr) begin
				len_q       <= len_clamped;
				rd_idx_q    <= '0;
				wr_idx_q    <= '0;
				fill_q      <= '0;
				rem_q       <= '0;
				ok_q        <= 1'b0;
				rd_active_q <= 1'b0;
				rd_left_q   <= '0;
			end else begin
				rd_idx_q    <= rd_idx_d;
				wr_idx_q    <= wr_idx_d;
				fill_q      <= fill_d;
				rem_q       <= rem_d;
				ok_q        <= ok_d;
				rd_active_q <= rd_active_d;
				rd_left_q   <= rd_left_d;
			end
		end
	end

	assign done       = done_s1;
	assign status     = status_s1;
	assign last       = last_s1;
	assign read_data  = rdsel_s1 ? DATA_W'(mem_q) : '0;
	assign filled     = FILL_W'(fill_s1);
	assign unfilled   = FILL_W'(unfill_s1);
	assign fifo_empty = (fill_s1 == '0);
	assign is_full    = (unfill_s1 == '0);

endmodule
